@@ rtl/core/srrw_pkg.sv @@
// Package for the selective-repeat receive window.
// Holds field widths, reset constants, controller state type and the
// command/status structs shared by the controller and the datapath.
package srrw_pkg;

  localparam int unsigned SEQ_W        = 32;
  localparam int unsigned BASE_W       = 31;
  localparam int unsigned SIZE_W       = 11;
  localparam int unsigned TAG_W        = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned WINDOW_SLOTS_DEF = 5;

  localparam logic [SIZE_W-1:0] FULL_SIZE_RST = 11'd1024;

  localparam logic RESULT_ACK = 1'b0;
  localparam logic RESULT_REL = 1'b1;

  localparam logic REG_FULL_SIZE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STORE,
    ST_READ,
    ST_REL
  } state_e;

  typedef struct packed {
    logic capture;
    logic store;
    logic rd_en;
    logic rd_next;
    logic release_pkt;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic chain_start;
    logic next_valid;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/core/selective_repeat_receive_window.sv @@
// Top level of the selective-repeat receive window: config register on an
// APB-style port, controller and datapath. Uses srrw_pkg, srrw_ctrl, srrw_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one packet descriptor word:
//   sequence number, payload size, payload tag. Output channel
//   (out_valid_o / out_stall_i) gives result words: first an acknowledgement,
//   then every in-order packet released from the window base, last_o set on
//   the final word of each input. done_res_o marks the release of a short
//   packet and every later word of that input; after that inputs are taken
//   and dropped until reset.
//   The ack is registered in the store state, once the output is free, after
//   the input is captured; the first release follows a registered read of the
//   slot RAM (read state, then release state), and each further release
//   follows directly while the output is not stalled (next slot read ahead).
//   An item passes idle and store, plus read and release if it releases packets.
//   Reset empties all slots, clears the window base and done flag, and sets
//   full_payload_size to 1024. A stalled output word holds; the block waits
//   and takes no new input until all words of the current input are loaded.
//   Register full_payload_size sits at byte address 0; write it only when idle.
module selective_repeat_receive_window
  import srrw_pkg::*;
#(
  parameter int unsigned WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [SEQ_W-1:0]  seq_number_i,
  input  logic [SIZE_W-1:0]        payload_size_i,
  input  logic [TAG_W-1:0]         payload_tag_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     result_kind_o,
  output logic signed [SEQ_W-1:0]  ack_seq_o,
  output logic [BASE_W-1:0]        released_seq_o,
  output logic [SIZE_W-1:0]        released_size_o,
  output logic [TAG_W-1:0]         released_tag_o,
  output logic                     last_o,
  output logic                     done_res_o
);

  logic [SIZE_W-1:0] full_size_q;
  logic              reg_sel;
  dp_cmd_t           cmd;
  dp_status_t        sts;

  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_FULL_SIZE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(DATA_W-SIZE_W){1'b0}}, full_size_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_size_q <= FULL_SIZE_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      full_size_q <= pwdata[SIZE_W-1:0];
    end
  end

  srrw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  srrw_datapath #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .full_size_i     (full_size_q),
    .seq_number_i    (seq_number_i),
    .payload_size_i  (payload_size_i),
    .payload_tag_i   (payload_tag_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .ack_seq_o       (ack_seq_o),
    .released_seq_o  (released_seq_o),
    .released_size_o (released_size_o),
    .released_tag_o  (released_tag_o),
    .last_o          (last_o),
    .done_res_o      (done_res_o)
  );

endmodule

@@ rtl/core/srrw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srrw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/srrw_ctrl.sv @@
// Controller of the selective-repeat receive window.
// Sequences capture, store/ack and the release chain; uses srrw_pkg.
module srrw_ctrl
  import srrw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output dp_cmd_t    cmd_o,
  input  dp_status_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        // items after the transfer ends are taken and dropped
        if (in_valid_i && !sts_i.finished) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_STORE;
        end
      end
      ST_STORE: begin
        if (sts_i.out_free) begin
          cmd_o.store = 1'b1;
          state_d     = sts_i.chain_start ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_REL;
      end
      ST_REL: begin
        if (sts_i.out_free) begin
          cmd_o.release_pkt = 1'b1;
          if (sts_i.next_valid) begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_next = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/srrw_datapath.sv @@
// Datapath of the selective-repeat receive window: window base, slot valid
// bits, slot RAM (size and tag), result register. Uses srrw_pkg, srrw_ram.
module srrw_datapath
  import srrw_pkg::*;
#(
  parameter int unsigned WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               sts_o,
  input  logic [SIZE_W-1:0]        full_size_i,
  input  logic signed [SEQ_W-1:0]  seq_number_i,
  input  logic [SIZE_W-1:0]        payload_size_i,
  input  logic [TAG_W-1:0]         payload_tag_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     result_kind_o,
  output logic signed [SEQ_W-1:0]  ack_seq_o,
  output logic [BASE_W-1:0]        released_seq_o,
  output logic [SIZE_W-1:0]        released_size_o,
  output logic [TAG_W-1:0]         released_tag_o,
  output logic                     last_o,
  output logic                     done_res_o
);

  localparam int unsigned IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int unsigned RAM_W = SIZE_W + TAG_W;
  localparam logic [IDX_W:0]    SLOTS_X  = (IDX_W+1)'(WINDOW_SLOTS);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_SLOTS - 1);
  localparam logic [BASE_W-1:0] SLOTS_B  = BASE_W'(WINDOW_SLOTS);

  logic signed [SEQ_W-1:0] seq_q;
  logic [SIZE_W-1:0]       size_q;
  logic [TAG_W-1:0]        tag_q;

  logic [WINDOW_SLOTS-1:0] valid_q, valid_d;
  logic [BASE_W-1:0]       base_q, base_d;
  logic [IDX_W-1:0]        base_idx_q, base_idx_d;
  logic                    finished_q, finished_d;

  logic                    out_valid_q, out_valid_d;
  logic                    kind_q;
  logic signed [SEQ_W-1:0] ack_q;
  logic [BASE_W-1:0]       rseq_q;
  logic [SIZE_W-1:0]       rsize_q;
  logic [TAG_W-1:0]        rtag_q;
  logic                    last_q;
  logic                    done_q;

  logic [BASE_W-1:0] offset;
  logic              in_window;
  logic [IDX_W:0]    idx_sum;
  logic [IDX_W:0]    idx_wrap;
  logic [IDX_W-1:0]  store_idx;
  logic              chain_start;
  logic [IDX_W-1:0]  next_idx;
  logic              next_valid;
  logic              out_free;
  logic [RAM_W-1:0]  rdata;
  logic [SIZE_W-1:0] rd_size;
  logic [TAG_W-1:0]  rd_tag;
  logic              is_short;
  logic [IDX_W-1:0]  raddr;

  // window test: base <= seq < base + slots, exact
  assign offset    = seq_q[BASE_W-1:0] - base_q;
  assign in_window = !seq_q[SEQ_W-1] && (seq_q[BASE_W-1:0] >= base_q) && (offset < SLOTS_B);
  assign idx_sum   = {1'b0, base_idx_q} + {1'b0, offset[IDX_W-1:0]};
  assign idx_wrap  = (idx_sum >= SLOTS_X) ? (idx_sum - SLOTS_X) : idx_sum;
  assign store_idx = idx_wrap[IDX_W-1:0];

  assign chain_start = valid_q[base_idx_q] || (in_window && (store_idx == base_idx_q));

  // base index follows base mod slots; base wraps at 2^31 back to slot 0
  always_comb begin
    if (base_q == '1) begin
      next_idx = '0;
    end else if (base_idx_q == LAST_IDX) begin
      next_idx = '0;
    end else begin
      next_idx = base_idx_q + IDX_W'(1);
    end
  end

  assign next_valid = valid_q[next_idx] && (next_idx != base_idx_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign rd_size  = rdata[RAM_W-1:TAG_W];
  assign rd_tag   = rdata[TAG_W-1:0];
  assign is_short = rd_size < full_size_i;
  assign raddr    = cmd_i.rd_next ? next_idx : base_idx_q;

  srrw_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WINDOW_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store && in_window),
    .waddr_i (store_idx),
    .wdata_i ({size_q, tag_q}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    valid_d     = valid_q;
    base_d      = base_q;
    base_idx_d  = base_idx_q;
    finished_d  = finished_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.store) begin
      out_valid_d = 1'b1;
      if (in_window) begin
        valid_d[store_idx] = 1'b1;
      end
    end
    if (cmd_i.release_pkt) begin
      out_valid_d         = 1'b1;
      valid_d[base_idx_q] = 1'b0;
      base_d              = base_q + BASE_W'(1);
      base_idx_d          = next_idx;
      if (is_short) begin
        finished_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      base_q      <= '0;
      base_idx_q  <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      base_q      <= base_d;
      base_idx_q  <= base_idx_d;
      finished_q  <= finished_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      seq_q  <= seq_number_i;
      size_q <= payload_size_i;
      tag_q  <= payload_tag_i;
    end
    if (cmd_i.store) begin
      kind_q  <= RESULT_ACK;
      ack_q   <= seq_q;
      rseq_q  <= '0;
      rsize_q <= '0;
      rtag_q  <= '0;
      last_q  <= !chain_start;
      done_q  <= 1'b0;
    end else if (cmd_i.release_pkt) begin
      kind_q  <= RESULT_REL;
      ack_q   <= '0;
      rseq_q  <= base_q;
      rsize_q <= rd_size;
      rtag_q  <= rd_tag;
      last_q  <= !next_valid;
      done_q  <= finished_q || is_short;
    end
  end

  assign sts_o.finished    = finished_q;
  assign sts_o.chain_start = chain_start;
  assign sts_o.next_valid  = next_valid;
  assign sts_o.out_free    = out_free;

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign ack_seq_o       = ack_q;
  assign released_seq_o  = rseq_q;
  assign released_size_o = rsize_q;
  assign released_tag_o  = rtag_q;
  assign last_o          = last_q;
  assign done_res_o      = done_q;

endmodule

@@ bench/selective_repeat_receive_window_tb.sv @@
// Testbench for selective_repeat_receive_window: random and directed packet words,
// a scoreboard class that predicts acks and in-order releases, APB config writes.
// Depends on srrw_pkg and the selective_repeat_receive_window RTL.
`timescale 1ns / 1ps

module selective_repeat_receive_window_tb;
  import srrw_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam logic [CFG_ADDR_W-1:0] FULL_SIZE_ADDR = CFG_ADDR_W'(4 * REG_FULL_SIZE);

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  ack;
    logic [BASE_W-1:0] rseq;
    logic [SIZE_W-1:0] rsize;
    logic [TAG_W-1:0]  rtag;
    logic              last;
    logic              done;
  } window_word_t;

  class window_scoreboard;
    logic [SEQ_W-1:0]  slot_seq  [WINDOW_SLOTS_DEF];
    logic [SIZE_W-1:0] slot_size [WINDOW_SLOTS_DEF];
    logic [TAG_W-1:0]  slot_tag  [WINDOW_SLOTS_DEF];
    logic [BASE_W-1:0] base;
    logic [SIZE_W-1:0] full_size;
    bit                finished;
    window_word_t      expected_words[$];
    int                mismatches;

    function new();
      for (int i = 0; i < WINDOW_SLOTS_DEF; i++) begin
        slot_seq[i]  = '1;
        slot_size[i] = '0;
        slot_tag[i]  = '0;
      end
      base       = '0;
      full_size  = FULL_SIZE_RST;
      finished   = 1'b0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) flag($sformatf("%s expected %h got %h", name, want, got));
    endfunction

    // ack first, then every in-order packet at the window base
    function void note_packet(logic [SEQ_W-1:0] seq, logic [SIZE_W-1:0] size,
                              logic [TAG_W-1:0] tag);
      window_word_t w;
      window_word_t burst[$];
      int unsigned  idx;
      if (finished) return;
      w = '0;
      w.kind = RESULT_ACK;
      w.ack  = seq;
      burst.push_back(w);
      if (!seq[SEQ_W-1] && {1'b0, seq} >= {2'b0, base} &&
          {1'b0, seq} < {2'b0, base} + WINDOW_SLOTS_DEF) begin
        idx = seq % WINDOW_SLOTS_DEF;
        slot_seq[idx]  = seq;
        slot_size[idx] = size;
        slot_tag[idx]  = tag;
        idx = base % WINDOW_SLOTS_DEF;
        while (slot_seq[idx] == {1'b0, base} && burst.size() < WINDOW_SLOTS_DEF + 1) begin
          if (slot_size[idx] < full_size) finished = 1'b1;
          w = '0;
          w.kind  = RESULT_REL;
          w.rseq  = base;
          w.rsize = slot_size[idx];
          w.rtag  = slot_tag[idx];
          w.done  = finished;
          burst.push_back(w);
          slot_seq[idx] = '1;
          base = base + 1'b1;
          idx  = base % WINDOW_SLOTS_DEF;
        end
      end
      w = burst.pop_back();
      w.last = 1'b1;
      burst.push_back(w);
      foreach (burst[i]) expected_words.push_back(burst[i]);
    endfunction

    function void check_word(window_word_t got);
      window_word_t want;
      if (expected_words.size() == 0) begin
        flag($sformatf("unexpected word kind %0d ack %h rel %0d", got.kind, got.ack, got.rseq));
        return;
      end
      want = expected_words.pop_front();
      compare("result_kind", want.kind, got.kind);
      compare("ack_seq", want.ack, got.ack);
      compare("released_seq", want.rseq, got.rseq);
      compare("released_size", want.rsize, got.rsize);
      compare("released_tag", want.rtag, got.rtag);
      compare("last", want.last, got.last);
      compare("done_res", want.done, got.done);
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CFG_ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [SEQ_W-1:0] seq_number_i;
  logic [SIZE_W-1:0]       payload_size_i;
  logic [TAG_W-1:0]        payload_tag_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    result_kind_o;
  logic signed [SEQ_W-1:0] ack_seq_o;
  logic [BASE_W-1:0]       released_seq_o;
  logic [SIZE_W-1:0]       released_size_o;
  logic [TAG_W-1:0]        released_tag_o;
  logic                    last_o;
  logic                    done_res_o;

  window_scoreboard sb;
  int sent_items  = 0;
  int idle_cycles = 0;
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;

  selective_repeat_receive_window DUT (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word({result_kind_o, ack_seq_o, released_seq_o, released_size_o,
                     released_tag_o, last_o, done_res_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stall before each word, one long hold-off on request
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 17);
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_word(input logic [SEQ_W-1:0] seq, input logic [SIZE_W-1:0] size,
                           input logic [TAG_W-1:0] tag);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    seq_number_i   <= seq;
    payload_size_i <= size;
    payload_tag_i  <= tag;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_packet(seq, size, tag);
    sent_items++;
  endtask

  task automatic sender_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_access(input bit wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= FULL_SIZE_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_full_size(input logic [SIZE_W-1:0] value);
    logic [DATA_W-1:0] rd;
    cfg_access(1'b1, DATA_W'(value), rd);
    sb.full_size = value;
    cfg_access(1'b0, '0, rd);
    sb.compare("full_payload_size readback", value, rd[SIZE_W-1:0]);
  endtask

  // sequence number that is never stored: terminator, negative, old or past the window
  function automatic logic [SEQ_W-1:0] noise_seq();
    logic [SEQ_W-1:0] s;
    case ($urandom_range(0, 4))
      0: s = '1;
      1: s = {1'b1, 31'($urandom)};
      2: s = {1'b0, 31'($urandom)};
      3: s = (sb.base == 0) ? '1 :
             {1'b0, sb.base} - $urandom_range(1, (sb.base > 20) ? 20 : sb.base);
      default: s = {1'b0, sb.base} + 5 + $urandom_range(0, 50);
    endcase
    if (!s[SEQ_W-1] && s >= {1'b0, sb.base} && s < {1'b0, sb.base} + 5) s = s + 5;
    return s;
  endfunction

  task automatic random_traffic(input int count, input int size_lo, input bit noise_only);
    int target;
    int pick;
    int j;
    int tmp;
    int off[5];
    logic [SEQ_W-1:0] base0;
    target = sent_items + count;
    while (sent_items < target) begin
      pick = noise_only ? 99 : $urandom_range(0, 99);
      if (pick < 55) begin
        base0 = {1'b0, sb.base};
        for (int i = 0; i < 5; i++) off[i] = i;
        for (int i = 4; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = off[i];
          off[i] = off[j];
          off[j] = tmp;
        end
        if ($urandom_range(0, 2) == 0) begin
          for (int i = 0; i < 5; i++)
            if (off[i] == 0) begin
              off[i] = off[4];
              off[4] = 0;
            end
        end
        for (int i = 0; i < 5; i++)
          send_word(base0 + off[i], SIZE_W'($urandom_range(size_lo, 1024)),
                    16'($urandom));
      end else if (pick < 85) begin
        send_word({1'b0, sb.base} + $urandom_range(0, 4),
                  SIZE_W'($urandom_range(size_lo, 1024)), 16'($urandom));
      end else begin
        send_word(noise_seq(), SIZE_W'($urandom_range(0, 1024)), 16'($urandom));
      end
    end
  endtask

  initial begin
    logic [DATA_W-1:0] rd;
    logic [SEQ_W-1:0]  base0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    seq_number_i   = '0;
    payload_size_i = '0;
    payload_tag_i  = '0;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_access(1'b0, '0, rd);
    sb.compare("full_payload_size after reset", FULL_SIZE_RST, rd[SIZE_W-1:0]);

    // directed, full size 1024: terminator, negatives, out of window, chains
    send_word('1, 11'd0, 16'h0000);
    send_word(32'h8000_0000, 11'd1024, 16'hFFFF);
    send_word(32'h7FFF_FFFF, 11'd1024, 16'h0000);
    send_word(32'd5, 11'd1023, 16'h00FF);
    send_word(32'd0, 11'd1024, 16'h1234);
    send_word(32'd0, 11'd1024, 16'h4321);
    send_word(32'd3, 11'd1024, 16'hAAAA);
    send_word(32'd2, 11'd1024, 16'h5555);
    send_word(32'd3, 11'd1024, 16'h0F0F);
    send_word(32'd4, 11'd1024, 16'hFFFF);
    send_word(32'd5, 11'd1024, 16'h0001);
    send_word(32'd1, 11'd1024, 16'h8000);
    send_word(32'd10, 11'd1024, 16'hFFFF);
    send_word(32'd7, 11'd1024, 16'h0000);
    sender_idle();

    // full size 0: nothing is ever short
    set_full_size(11'd0);
    random_traffic(60, 0, 1'b0);
    hold_req = 1'b1;
    random_traffic(40, 0, 1'b0);
    sender_idle();
    quiet = 1'b1;
    random_traffic(40, 0, 1'b0);
    quiet = 1'b0;
    random_traffic(60, 0, 1'b0);
    sender_idle();

    // full size above range: only words that are never stored
    set_full_size(11'd2047);
    random_traffic(15, 0, 1'b1);
    sender_idle();

    // full size 1, then a chain that releases a short packet mid-way
    set_full_size(11'd1);
    random_traffic(20, 1, 1'b0);
    base0 = {1'b0, sb.base};
    send_word(base0 + 1, 11'd1024, 16'($urandom));
    send_word(base0 + 2, 11'd0, 16'($urandom));
    send_word(base0 + 3, 11'd512, 16'($urandom));
    send_word(base0 + 4, 11'd1, 16'($urandom));
    send_word(base0, 11'd1024, 16'($urandom));
    // transfer is done: these are dropped
    random_traffic(5, 0, 1'b0);
    sender_idle();

    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
